>>> src/hkrf_pkg.sv
// hkrf_pkg: shared types, codes and constant tables of the keyboard report framer.
// Holds the beat payload structs, the microcode word layout and the ASCII usage table.
// No dependencies; used by every other file of the block.
package hkrf_pkg;

  // Input beat payload
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key_code;
    logic       hold_or_tap;
    logic       send_after_release;
  } in_t;

  // Result beat payload
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       frame_sent;
    logic [1:0] status;
  } out_t;

  typedef enum logic [1:0] {
    OP_PRESS       = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2,
    OP_WRITE       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Microcode fields
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DECODE,
    ACT_APPLY,
    ACT_POST
  } act_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_FRAME,
    EMIT_SINGLE
  } emit_e;

  typedef enum logic [2:0] {
    C_NEXT,     // fall through
    C_WAIT_IN,  // hold until an input beat is taken
    C_SILENT,   // jump when the update sends no frame
    C_BYTES,    // hold until the last frame byte is out, then jump
    C_EMIT,     // hold until the single result is out, then fall through
    C_GOTO      // unconditional jump
  } cond_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_FETCH  = 3'd0;
  localparam step_t STEP_DECODE = 3'd1;
  localparam step_t STEP_APPLY  = 3'd2;
  localparam step_t STEP_FRAME  = 3'd3;
  localparam step_t STEP_SINGLE = 3'd4;
  localparam step_t STEP_POST   = 3'd5;

  typedef struct packed {
    act_e  act;
    emit_e emit;
    cond_e cond;
    step_t jmp;
  } ctrl_t;

  // Sequencer to datapath
  typedef struct packed {
    ctrl_t cw;
    logic  in_fire;
  } seq_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic silent;
    logic emit_done;
    logic last_byte;
  } dp_stat_t;

  // Key code ranges and report constants
  localparam logic [7:0] CODE_RAW   = 8'd136;
  localparam logic [7:0] CODE_MOD   = 8'd128;
  localparam logic [7:0] SHIFT_FLAG = 8'h80;
  localparam logic [7:0] LEFT_SHIFT = 8'h02;
  localparam logic [7:0] USAGE_MASK = 8'h7F;
  localparam logic [7:0] FLAG_TAP   = 8'h11;
  localparam logic [7:0] FLAG_HOLD  = 8'h00;
  localparam logic [7:0] CH_K       = 8'h4B;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam int unsigned HEAD_LEN  = 4;
  localparam int unsigned TAIL_LEN  = 5;

  // ASCII to usage; bit 7 requests left shift, zero means no mapping
  localparam logic [7:0] CHAR_USAGE [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
    8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
    8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
    8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

endpackage

>>> src/hkrf_ucode_rom.sv
// hkrf_ucode_rom: read-only control store of the report framer sequencer.
// One control word per step; depends on hkrf_pkg.
module hkrf_ucode_rom (
  input  hkrf_pkg::step_t step_i,
  output hkrf_pkg::ctrl_t cw_o
);

  // Program: fetch, decode, apply, frame bytes or single result, post
  always_comb begin
    unique case (step_i)
      hkrf_pkg::STEP_FETCH: begin
        cw_o = '{hkrf_pkg::ACT_LOAD, hkrf_pkg::EMIT_NONE, hkrf_pkg::C_WAIT_IN,
                 hkrf_pkg::STEP_FETCH};
      end
      hkrf_pkg::STEP_DECODE: begin
        cw_o = '{hkrf_pkg::ACT_DECODE, hkrf_pkg::EMIT_NONE, hkrf_pkg::C_NEXT,
                 hkrf_pkg::STEP_FETCH};
      end
      hkrf_pkg::STEP_APPLY: begin
        cw_o = '{hkrf_pkg::ACT_APPLY, hkrf_pkg::EMIT_NONE, hkrf_pkg::C_SILENT,
                 hkrf_pkg::STEP_SINGLE};
      end
      hkrf_pkg::STEP_FRAME: begin
        cw_o = '{hkrf_pkg::ACT_NONE, hkrf_pkg::EMIT_FRAME, hkrf_pkg::C_BYTES,
                 hkrf_pkg::STEP_POST};
      end
      hkrf_pkg::STEP_SINGLE: begin
        cw_o = '{hkrf_pkg::ACT_NONE, hkrf_pkg::EMIT_SINGLE, hkrf_pkg::C_EMIT,
                 hkrf_pkg::STEP_FETCH};
      end
      hkrf_pkg::STEP_POST: begin
        cw_o = '{hkrf_pkg::ACT_POST, hkrf_pkg::EMIT_NONE, hkrf_pkg::C_GOTO,
                 hkrf_pkg::STEP_FETCH};
      end
      default: begin
        cw_o = '{hkrf_pkg::ACT_NONE, hkrf_pkg::EMIT_NONE, hkrf_pkg::C_GOTO,
                 hkrf_pkg::STEP_FETCH};
      end
    endcase
  end

endmodule

>>> src/hkrf_seq.sv
// hkrf_seq: step counter and branch logic of the report framer.
// Fetches control words from hkrf_ucode_rom; depends on hkrf_pkg.
module hkrf_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hkrf_pkg::dp_stat_t  stat_i,
  output hkrf_pkg::seq_ctl_t  ctl_o
);

  hkrf_pkg::step_t step_q, step_d;
  hkrf_pkg::ctrl_t cw;

  hkrf_ucode_rom u_rom (
    .step_i (step_q),
    .cw_o   (cw)
  );

  assign in_ready_o   = (cw.act == hkrf_pkg::ACT_LOAD);
  assign ctl_o.cw      = cw;
  assign ctl_o.in_fire = in_ready_o & in_valid_i;

  // Next step: fall through, hold or jump by the word's condition
  always_comb begin
    step_d = step_q;
    case (cw.cond)
      hkrf_pkg::C_NEXT:    step_d = step_q + 3'd1;
      hkrf_pkg::C_WAIT_IN: step_d = ctl_o.in_fire ? step_q + 3'd1 : step_q;
      hkrf_pkg::C_SILENT:  step_d = stat_i.silent ? cw.jmp : step_q + 3'd1;
      hkrf_pkg::C_BYTES:   step_d = (stat_i.emit_done && stat_i.last_byte) ? cw.jmp : step_q;
      hkrf_pkg::C_EMIT:    step_d = stat_i.emit_done ? step_q + 3'd1 : step_q;
      hkrf_pkg::C_GOTO:    step_d = cw.jmp;
      default:             step_d = hkrf_pkg::STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= hkrf_pkg::STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> src/hkrf_datapath.sv
// hkrf_datapath: key slots, modifier byte, key decode, frame byte mux and result register.
// Driven by control words from hkrf_seq; depends on hkrf_pkg.
module hkrf_datapath #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hkrf_pkg::in_t       in_data_i,
  input  hkrf_pkg::seq_ctl_t  ctl_i,
  output hkrf_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hkrf_pkg::out_t      out_data_o
);

  localparam int unsigned FRAME_LEN = hkrf_pkg::HEAD_LEN + KEY_SLOTS + hkrf_pkg::TAIL_LEN;
  localparam int unsigned BW        = $clog2(FRAME_LEN);

  // Report state
  logic [7:0] mods_q, mods_d;
  logic [7:0] slots_q [KEY_SLOTS];
  logic [7:0] slots_d [KEY_SLOTS];

  // Item and decode registers
  hkrf_pkg::in_t item_q;
  logic [7:0]    usage_q, usage_d;
  logic [7:0]    mask_q, mask_d;
  logic          unm_q, unm_d;

  // Update results
  logic [1:0]    status_q, status_d;
  logic          silent_q, silent_d;
  logic [7:0]    flag_q, flag_d;

  // Frame byte counter and result register
  logic [BW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  hkrf_pkg::out_t out_q, out_d;

  logic [KEY_SLOTS-1:0] match_vec, free_vec, first_free;
  logic [7:0]    tbl, frame_byte;
  logic [BW-1:0] slot_off, tail_off;
  logic          emit_ok, emit_done, last_byte;
  hkrf_pkg::op_e op;

  assign op = hkrf_pkg::op_e'(item_q.operation);

  // Per-slot compare and first empty slot
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match_vec[i] = (slots_q[i] == usage_q) && (usage_q != 8'd0);
      free_vec[i]  = (slots_q[i] == 8'd0);
    end
    first_free = free_vec & ~(free_vec - KEY_SLOTS'(1));
  end

  // Key code decode
  always_comb begin
    tbl     = hkrf_pkg::CHAR_USAGE[item_q.key_code[6:0]];
    usage_d = 8'd0;
    mask_d  = 8'd0;
    unm_d   = 1'b0;
    if (item_q.key_code >= hkrf_pkg::CODE_RAW) begin
      usage_d = item_q.key_code - hkrf_pkg::CODE_RAW;
    end else if (item_q.key_code >= hkrf_pkg::CODE_MOD) begin
      mask_d = 8'd1 << item_q.key_code[2:0];
    end else begin
      unm_d   = (tbl == 8'd0);
      usage_d = tbl & hkrf_pkg::USAGE_MASK;
      mask_d  = ((tbl & hkrf_pkg::SHIFT_FLAG) != 8'd0) ? hkrf_pkg::LEFT_SHIFT : 8'd0;
    end
  end

  // Report update for apply and post steps
  always_comb begin
    mods_d   = mods_q;
    slots_d  = slots_q;
    status_d = status_q;
    silent_d = silent_q;
    flag_d   = flag_q;
    if (ctl_i.cw.act == hkrf_pkg::ACT_APPLY) begin
      status_d = hkrf_pkg::ST_OK;
      silent_d = 1'b0;
      flag_d   = hkrf_pkg::FLAG_HOLD;
      case (op) inside
        hkrf_pkg::OP_PRESS, hkrf_pkg::OP_WRITE: begin
          if (op == hkrf_pkg::OP_WRITE || item_q.hold_or_tap) begin
            flag_d = hkrf_pkg::FLAG_TAP;
          end
          if (unm_q) begin
            status_d = hkrf_pkg::ST_UNMAPPED;
            silent_d = 1'b1;
          end else begin
            mods_d = mods_q | mask_q;
            if (usage_q != 8'd0 && match_vec == '0) begin
              if (free_vec != '0) begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                  if (first_free[i]) begin
                    slots_d[i] = usage_q;
                  end
                end
              end else begin
                status_d = hkrf_pkg::ST_FULL;
                silent_d = 1'b1;
              end
            end
          end
        end
        hkrf_pkg::OP_RELEASE: begin
          if (unm_q) begin
            status_d = hkrf_pkg::ST_UNMAPPED;
            silent_d = 1'b1;
          end else begin
            mods_d   = mods_q & ~mask_q;
            silent_d = ~item_q.send_after_release;
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (match_vec[i]) begin
                slots_d[i] = 8'd0;
              end
            end
          end
        end
        default: begin
          mods_d = 8'd0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_d[i] = 8'd0;
          end
        end
      endcase
    end else if (ctl_i.cw.act == hkrf_pkg::ACT_POST) begin
      // silent release that closes a write
      if (op == hkrf_pkg::OP_WRITE && !unm_q) begin
        mods_d = mods_q & ~mask_q;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (match_vec[i]) begin
            slots_d[i] = 8'd0;
          end
        end
      end
    end
  end

  // Frame byte select
  always_comb begin
    slot_off   = idx_q - BW'(hkrf_pkg::HEAD_LEN);
    tail_off   = idx_q - BW'(hkrf_pkg::HEAD_LEN + KEY_SLOTS);
    frame_byte = 8'd0;
    if (idx_q == BW'(0)) begin
      frame_byte = hkrf_pkg::CH_K;
    end else if (idx_q == BW'(1)) begin
      frame_byte = flag_q;
    end else if (idx_q == BW'(2)) begin
      frame_byte = mods_q;
    end else if (idx_q == BW'(3)) begin
      frame_byte = 8'd0;
    end else if (idx_q < BW'(hkrf_pkg::HEAD_LEN + KEY_SLOTS)) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (slot_off == BW'(i)) begin
          frame_byte = slots_q[i];
        end
      end
    end else begin
      case (tail_off)
        BW'(0):  frame_byte = hkrf_pkg::CH_A;
        BW'(1):  frame_byte = hkrf_pkg::CH_T;
        BW'(2):  frame_byte = hkrf_pkg::CH_C;
        BW'(3):  frame_byte = hkrf_pkg::CH_CR;
        default: frame_byte = hkrf_pkg::CH_LF;
      endcase
    end
  end

  // Result register and byte counter
  assign emit_ok   = ~out_valid_q | out_ready_i;
  assign emit_done = (ctl_i.cw.emit != hkrf_pkg::EMIT_NONE) & emit_ok;
  assign last_byte = (idx_q == BW'(FRAME_LEN - 1));

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    idx_d       = idx_q;
    if (emit_done) begin
      out_valid_d = 1'b1;
      if (ctl_i.cw.emit == hkrf_pkg::EMIT_FRAME) begin
        out_d = '{frame_byte, last_byte, 1'b1, hkrf_pkg::ST_OK};
        idx_d = last_byte ? '0 : idx_q + BW'(1);
      end else begin
        out_d = '{8'd0, 1'b1, 1'b0, status_q};
      end
    end
  end

  assign stat_o.silent    = silent_d;
  assign stat_o.emit_done = emit_done;
  assign stat_o.last_byte = last_byte;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

  // Control and report state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q      <= 8'd0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots_q[i] <= 8'd0;
      end
    end else begin
      mods_q      <= mods_d;
      slots_q     <= slots_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.in_fire) begin
      item_q <= in_data_i;
    end
    if (ctl_i.cw.act == hkrf_pkg::ACT_DECODE) begin
      usage_q <= usage_d;
      mask_q  <= mask_d;
      unm_q   <= unm_d;
    end
    status_q <= status_d;
    silent_q <= silent_d;
    flag_q   <= flag_d;
    out_q    <= out_d;
  end

endmodule

>>> src/hid_keyboard_report_framer.sv
// hid_keyboard_report_framer: top level of the boot keyboard report framer.
// Ties hkrf_seq (microcode sequencer) to hkrf_datapath; depends on hkrf_pkg.

// The block keeps a boot keyboard report (modifier byte plus KEY_SLOTS usage
// slots) and turns each key command into result beats: either a whole report
// frame of 9 + KEY_SLOTS bytes ('K', flag, modifiers, 0, slots, "ATC\r\n"),
// one byte per beat, or a single status beat when nothing is sent. A short
// microprogram runs each item in steps: take the item, decode the key
// code, update the report, send the result beats, and a closing step that
// does the silent release of a write. The output side can stall the result
// beats. The step counter runs one item at a time; the result register lets
// the last beat of an item wait while the next item is taken.
module hid_keyboard_report_framer #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hkrf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hkrf_pkg::out_t out_data_o
);

  hkrf_pkg::seq_ctl_t ctl;
  hkrf_pkg::dp_stat_t stat;

  hkrf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  hkrf_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/hkrf_checker.sv
// hkrf_checker: port-level assertions for hid_keyboard_report_framer, and its bind.
// Sees only the top-level ports; depends on hkrf_pkg.
module hkrf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input hkrf_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input hkrf_pkg::out_t out_data_o
);

  logic out_fire;
  assign out_fire = out_valid_o & out_ready_i;

  // a waiting input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one item at a time: no new item right after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // a beat outside a frame is the only beat of its item and carries no byte
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !out_data_o.frame_sent |->
      out_data_o.last_byte && out_data_o.tx_byte == 8'd0)
    else $error("bad no-frame beat");

  // frame beats always report success
  a_frame_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_o.frame_sent |-> out_data_o.status == hkrf_pkg::ST_OK)
    else $error("frame beat with error status");

endmodule

bind hid_keyboard_report_framer hkrf_checker u_hkrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
